// File: rtl/core/mtos_pkg.sv
// ----------------------------------------------------------------------------
// mtos_pkg
// Shared types, codes and constants of the motor trajectory outscan core.
// ----------------------------------------------------------------------------
package mtos_pkg;

  localparam int unsigned TableRowsDef = 1024;
  localparam int unsigned Steppers     = 2;
  localparam int unsigned ClkdirMotors = 2;
  localparam int unsigned Motors       = Steppers + ClkdirMotors;
  localparam int unsigned HalfSteps    = 8;
  localparam int unsigned PhaseW       = $clog2(HalfSteps);

  localparam int unsigned FuncW      = 3;
  localparam int unsigned RowW       = 10;
  localparam int unsigned MotorW     = 2;
  localparam int unsigned PosW       = 32;
  localparam int unsigned PtrW       = 11;
  localparam int unsigned LenW       = 11;
  localparam int unsigned TrigRowW   = 11;
  localparam int unsigned TrigWidthW = 16;
  localparam int unsigned Triggers   = 2;
  localparam int unsigned CmpW       = 17;
  localparam int unsigned ApbAddrW   = 5;
  localparam int unsigned ApbDataW   = 32;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK     = 3'd0,
    FUNC_LOAD     = 3'd1,
    FUNC_START    = 3'd2,
    FUNC_STOP     = 3'd3,
    FUNC_ZERO_ROW = 3'd4,
    FUNC_ZERO_POS = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    REG_TABLE_LENGTH = 3'd0,
    REG_LOOP_MODE    = 3'd1,
    REG_MOVE_MODE    = 3'd2,
    REG_TRIG0_ROW    = 3'd3,
    REG_TRIG0_WIDTH  = 3'd4,
    REG_TRIG1_ROW    = 3'd5,
    REG_TRIG1_WIDTH  = 3'd6
  } reg_e;

  typedef struct packed {
    logic [LenW-1:0]                      table_length;
    logic                                 wrap_en;
    logic                                 move_mode;
    logic [Triggers-1:0][TrigRowW-1:0]    trig_row;
    logic [Triggers-1:0][TrigWidthW-1:0]  trig_len;
  } cfg_t;

  function automatic logic [3:0] coil_nibble(input logic [PhaseW-1:0] phase);
    logic [3:0] nib;
    case (phase)
      3'd0:    nib = 4'he;
      3'd1:    nib = 4'hc;
      3'd2:    nib = 4'hd;
      3'd3:    nib = 4'h9;
      3'd4:    nib = 4'hb;
      3'd5:    nib = 4'h3;
      3'd6:    nib = 4'h7;
      default: nib = 4'h6;
    endcase
    return nib;
  endfunction

endpackage

// File: rtl/core/mtos_if.sv
// ----------------------------------------------------------------------------
// mtos_if
// Request and result channels of the motor trajectory outscan core.
// ----------------------------------------------------------------------------
interface mtos_in_if;
  import mtos_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FuncW-1:0]         func;
  logic [RowW-1:0]          row;
  logic [MotorW-1:0]        motor;
  logic signed [PosW-1:0]   value;
  modport source (output valid, func, row, motor, value, input ready);
  modport sink   (input valid, func, row, motor, value, output ready);
endinterface

interface mtos_out_if;
  import mtos_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [7:0]               step_pattern;
  logic [ClkdirMotors-1:0]  clock_pulse;
  logic [ClkdirMotors-1:0]  direction_level;
  logic [Triggers-1:0]      trigger_level;
  logic [RowW-1:0]          row_pointer;
  logic                     running;
  logic signed [PosW-1:0]   selected_position;
  modport source (output valid, step_pattern, clock_pulse, direction_level,
                  trigger_level, row_pointer, running, selected_position, input ready);
  modport sink   (input valid, step_pattern, clock_pulse, direction_level,
                  trigger_level, row_pointer, running, selected_position, output ready);
endinterface

// File: rtl/core/motor_trajectory_outscan_core.sv
// ----------------------------------------------------------------------------
// motor_trajectory_outscan_core
// Table-driven sequencer for two half-step steppers and two motors with
// clock/direction drive, and with two trigger outputs.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          contents
//  in_i      in         valid/ready        func, row, motor, value
//  out_o     out        valid/ready        coils, pulses, directions, status
//  apb       in         psel/penable/...   configuration registers
//
//  One request is taken every cycle while the result side is not stalled.
//  The target table sits in one synchronous memory holding a full row per
//  word, so a tick needs a single read; row 0 is mirrored in registers.
//  After reset the table is undefined until loaded; there is no clearing pass.
//  A stalled result holds the second stage, which then holds the input side.
// ----------------------------------------------------------------------------
module motor_trajectory_outscan_core #(
  parameter int unsigned TABLE_ROWS = mtos_pkg::TableRowsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mtos_in_if.sink                        in_i,
  mtos_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mtos_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mtos_pkg::ApbDataW-1:0]  pwdata,
  output logic [mtos_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import mtos_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ROWS);

  cfg_t cfg;

  mtos_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // First stage: control state.
  logic [PtrW-1:0]                       row_q, row_d;
  logic                                  run_q, run_d;
  logic                                  was_q, was_d;
  logic [Triggers-1:0]                   act_q, act_d;
  logic [Triggers-1:0][TrigWidthW-1:0]   ticks_q, ticks_d;
  logic [Motors-1:0][PosW-1:0]           row0_q;

  logic                                  in_acc;
  logic                                  tbl_we, tbl_re;
  logic [CmpW-1:0]                       addr_ext;
  logic [CmpW-1:0]                       eff_len;
  logic                                  mov, rowz, zpos;
  logic                                  tr_a;
  logic [TrigWidthW-1:0]                 tr_k;
  logic [PtrW-1:0]                       ri, nxt;

  // Second stage.
  logic                                  s1_valid_q;
  logic [FuncW-1:0]                      s1_func_q;
  logic [MotorW-1:0]                     s1_motor_q;
  logic                                  s1_move_q, s1_rowz_q, s1_zpos_q;
  logic [RowW-1:0]                       s1_row_q;
  logic                                  s1_run_q;
  logic [Triggers-1:0]                   s1_trig_q;
  logic                                  s1_adv;

  logic [Motors-1:0][PosW-1:0]           tbl_mem [TABLE_ROWS];
  logic [Motors-1:0][PosW-1:0]           rd_q;

  logic [Motors-1:0][PosW-1:0]           pos_q, pos_d;
  logic [Motors-1:0][PosW-1:0]           start_q, start_d;
  logic [Steppers-1:0][PhaseW-1:0]       phase_q, phase_d;
  logic [ClkdirMotors-1:0]               dir_q, dir_d;
  logic [7:0]                            coil_q, coil_d;
  logic [ClkdirMotors-1:0]               pulse_d;

  logic [PosW-1:0]                       st_n, own, want;
  logic [Motors-1:0]                     up_v, dn_v;

  logic                                  out_valid_q;

  assign in_acc   = in_i.valid && in_i.ready;
  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign eff_len  = (CmpW'(cfg.table_length) < CmpW'(TABLE_ROWS)) ?
                    CmpW'(cfg.table_length) : CmpW'(TABLE_ROWS);

  always_comb begin
    row_d    = row_q;
    run_d    = run_q;
    was_d    = was_q;
    act_d    = act_q;
    ticks_d  = ticks_q;
    tbl_we   = 1'b0;
    tbl_re   = 1'b0;
    addr_ext = '0;
    mov      = 1'b0;
    rowz     = 1'b0;
    zpos     = 1'b0;
    tr_a     = 1'b0;
    tr_k     = '0;
    ri       = '0;
    nxt      = '0;
    if (in_acc) begin
      case (in_i.func)
        FUNC_TICK: begin
          if (!cfg.move_mode) begin
            for (int t = 0; t < Triggers; t++) begin
              tr_a = act_q[t] || (!cfg.trig_row[t][TrigRowW-1] &&
                                  cfg.trig_row[t] == row_q && run_q);
              tr_k = tr_a ? ticks_q[t] + TrigWidthW'(1) : ticks_q[t];
              if (tr_k >= cfg.trig_len[t]) begin
                tr_a = 1'b0;
                tr_k = '0;
              end
              act_d[t]   = tr_a;
              ticks_d[t] = tr_k;
            end
          end
          if (!run_q) begin
            was_d = 1'b0;
          end else begin
            ri = (!was_q && CmpW'(row_q) >= eff_len) ? '0 : row_q;
            if (CmpW'(ri) < CmpW'(TABLE_ROWS)) begin
              addr_ext = CmpW'(ri);
            end
            tbl_re = 1'b1;
            mov    = 1'b1;
            rowz   = (addr_ext == '0);
            nxt    = ri + PtrW'(1);
            if (CmpW'(nxt) >= eff_len) begin
              nxt = '0;
              if (!cfg.wrap_en) begin
                run_d = 1'b0;
              end
            end
            row_d = nxt;
            was_d = run_d;
          end
        end
        FUNC_LOAD: begin
          if (!run_q && CmpW'(in_i.row) < CmpW'(TABLE_ROWS)) begin
            tbl_we   = 1'b1;
            addr_ext = CmpW'(in_i.row);
          end
        end
        FUNC_START: run_d = 1'b1;
        FUNC_STOP:  run_d = 1'b0;
        FUNC_ZERO_ROW: begin
          if (!run_q) begin
            row_d = '0;
          end
        end
        FUNC_ZERO_POS: zpos = !run_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[addr_ext[AW-1:0]][in_i.motor] <= in_i.value;
    end
    if (tbl_re) begin
      rd_q <= tbl_mem[addr_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we && addr_ext == '0) begin
      row0_q[in_i.motor] <= in_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      run_q      <= 1'b0;
      was_q      <= 1'b0;
      act_q      <= '0;
      ticks_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      row_q   <= row_d;
      run_q   <= run_d;
      was_q   <= was_d;
      act_q   <= act_d;
      ticks_q <= ticks_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q  <= in_i.func;
      s1_motor_q <= in_i.motor;
      s1_move_q  <= mov;
      s1_rowz_q  <= rowz;
      s1_zpos_q  <= zpos;
      s1_row_q   <= row_d[RowW-1:0];
      s1_run_q   <= run_d;
      s1_trig_q  <= act_d;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    start_d = start_q;
    phase_d = phase_q;
    dir_d   = dir_q;
    coil_d  = coil_q;
    pulse_d = '0;
    st_n    = '0;
    own     = '0;
    want    = '0;
    up_v    = '0;
    dn_v    = '0;
    if (s1_adv && s1_move_q) begin
      for (int i = 0; i < Motors; i++) begin
        st_n = s1_rowz_q ? pos_q[i] : start_q[i];
        own  = pos_q[i] - st_n;
        want = rd_q[i] - row0_q[i];
        up_v[i] = $signed(want) > $signed(own);
        dn_v[i] = (want != own) && !up_v[i];
        start_d[i] = st_n;
        if (up_v[i]) begin
          pos_d[i] = pos_q[i] + PosW'(1);
        end else if (dn_v[i]) begin
          pos_d[i] = pos_q[i] - PosW'(1);
        end
      end
      for (int s = 0; s < Steppers; s++) begin
        if (up_v[s]) begin
          phase_d[s] = phase_q[s] + PhaseW'(1);
        end else if (dn_v[s]) begin
          phase_d[s] = phase_q[s] - PhaseW'(1);
        end
      end
      for (int c = 0; c < ClkdirMotors; c++) begin
        if (up_v[Steppers+c]) begin
          dir_d[c] = 1'b1;
        end else if (dn_v[Steppers+c]) begin
          dir_d[c] = 1'b0;
        end
        pulse_d[c] = up_v[Steppers+c] || dn_v[Steppers+c];
      end
      coil_d = {coil_nibble(phase_d[1]), coil_nibble(phase_d[0])};
    end else if (s1_adv && s1_zpos_q) begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      start_q     <= '0;
      phase_q     <= '0;
      dir_q       <= '0;
      coil_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      start_q <= start_d;
      phase_q <= phase_d;
      dir_q   <= dir_d;
      coil_q  <= coil_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_o.step_pattern      <= coil_d;
      out_o.clock_pulse       <= pulse_d;
      out_o.direction_level   <= dir_d;
      out_o.trigger_level     <= s1_trig_q;
      out_o.row_pointer       <= s1_row_q;
      out_o.running           <= s1_run_q;
      out_o.selected_position <= pos_d[s1_motor_q];
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef ASSERT_OFF
  a_no_load_while_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> !run_q) else $error("table written while running");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q) else $error("result lost");

  a_pulse_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_func_q != FUNC_TICK) |=> (out_o.clock_pulse == '0))
    else $error("clock pulse on a request that is not a tick");
`endif

endmodule

// File: rtl/core/mtos_regs.sv
// ----------------------------------------------------------------------------
// mtos_regs
// APB configuration registers of the motor trajectory outscan core.
// ----------------------------------------------------------------------------
module mtos_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mtos_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mtos_pkg::ApbDataW-1:0]  pwdata,
  output logic [mtos_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output mtos_pkg::cfg_t                 cfg_o
);
  import mtos_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_TABLE_LENGTH: cfg_d.table_length = pwdata[LenW-1:0];
        REG_LOOP_MODE:    cfg_d.wrap_en      = pwdata[0];
        REG_MOVE_MODE:    cfg_d.move_mode    = pwdata[0];
        REG_TRIG0_ROW:    cfg_d.trig_row[0]  = pwdata[TrigRowW-1:0];
        REG_TRIG0_WIDTH:  cfg_d.trig_len[0]  = pwdata[TrigWidthW-1:0];
        REG_TRIG1_ROW:    cfg_d.trig_row[1]  = pwdata[TrigRowW-1:0];
        REG_TRIG1_WIDTH:  cfg_d.trig_len[1]  = pwdata[TrigWidthW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TABLE_LENGTH: prdata = ApbDataW'(cfg_q.table_length);
      REG_LOOP_MODE:    prdata = ApbDataW'(cfg_q.wrap_en);
      REG_MOVE_MODE:    prdata = ApbDataW'(cfg_q.move_mode);
      REG_TRIG0_ROW:    prdata = ApbDataW'(cfg_q.trig_row[0]);
      REG_TRIG0_WIDTH:  prdata = ApbDataW'(cfg_q.trig_len[0]);
      REG_TRIG1_ROW:    prdata = ApbDataW'(cfg_q.trig_row[1]);
      REG_TRIG1_WIDTH:  prdata = ApbDataW'(cfg_q.trig_len[1]);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_length <= LenW'(1);
      cfg_q.wrap_en      <= 1'b0;
      cfg_q.move_mode    <= 1'b0;
      cfg_q.trig_row[0]  <= '1;
      cfg_q.trig_row[1]  <= '1;
      cfg_q.trig_len[0]  <= TrigWidthW'(1);
      cfg_q.trig_len[1]  <= TrigWidthW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: sim/motor_trajectory_outscan_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_trajectory_outscan_core_test
// Self-checking bench for the trajectory outscan core. Requests are produced
// together with their predicted results by an in-bench model of the
// sequencer. A driver and a monitor then move them through the block with
// random idling, and every result is compared with its prediction.
// ----------------------------------------------------------------------------
module motor_trajectory_outscan_core_test;
  import mtos_pkg::*;

  typedef struct {
    logic [2:0]  func;
    logic [9:0]  row;
    logic [1:0]  motor;
    logic [31:0] value;
  } request_t;

  typedef struct {
    logic [7:0]  coils;
    logic [1:0]  pulse;
    logic [1:0]  dir;
    logic [1:0]  trig;
    logic [9:0]  ptr;
    logic        run;
    logic [31:0] pos;
  } outcome_t;

  localparam logic [7:0] HALF_STEP_SEQ [8] = '{8'h0e, 8'h0c, 8'h0d, 8'h09,
                                               8'h0b, 8'h03, 8'h07, 8'h06};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  mtos_in_if  in_ch ();
  mtos_out_if out_ch ();

  motor_trajectory_outscan_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  request_t pending_requests[$];
  outcome_t predicted_results[$];
  int idle_pct = 30;
  bit hold_sender = 1'b0;
  bit failed = 1'b0;
  int random_items = 0;
  bit counting = 1'b0;

  // Sequencer image: settings and state.
  logic [10:0] cfg_len;
  logic        cfg_loop, cfg_move;
  logic [10:0] cfg_trow [2];
  logic [15:0] cfg_twid [2];
  logic [31:0] targets [1024][4];
  bit          loaded [1024][4];
  logic [31:0] position [4];
  logic [31:0] origin [4];
  logic [2:0]  phase [2];
  logic [1:0]  held_dir;
  logic [7:0]  coils;
  int          row_ptr;
  bit          running, was_running;
  bit          trig_on [2];
  logic [15:0] trig_count [2];

  function automatic int active_length();
    return (cfg_len < 1024) ? int'(cfg_len) : 1024;
  endfunction

  function automatic void step_triggers();
    if (cfg_move) return;
    for (int t = 0; t < 2; t++) begin
      if (!cfg_trow[t][10] && int'(cfg_trow[t]) == row_ptr && running) trig_on[t] = 1'b1;
      if (trig_on[t]) trig_count[t] = trig_count[t] + 16'd1;
      if (trig_count[t] >= cfg_twid[t]) begin
        trig_on[t] = 1'b0;
        trig_count[t] = '0;
      end
    end
  endfunction

  function automatic logic [1:0] step_motors();
    logic [1:0] pulses;
    logic signed [31:0] own, want;
    pulses = '0;
    if (!running) begin
      was_running = 1'b0;
      return pulses;
    end
    if (!was_running && row_ptr >= active_length()) row_ptr = 0;
    for (int i = 0; i < 4; i++) begin
      if (row_ptr == 0) origin[i] = position[i];
      own  = position[i] - origin[i];
      want = targets[row_ptr][i] - targets[0][i];
      if (want == own) continue;
      if (want > own) begin
        position[i] = position[i] + 1;
        if (i < 2) phase[i] = phase[i] + 3'd1;
        else held_dir[i-2] = 1'b1;
      end else begin
        position[i] = position[i] - 1;
        if (i < 2) phase[i] = phase[i] - 3'd1;
        else held_dir[i-2] = 1'b0;
      end
      if (i >= 2) pulses[i-2] = 1'b1;
    end
    coils = {HALF_STEP_SEQ[phase[1]][3:0], HALF_STEP_SEQ[phase[0]][3:0]};
    row_ptr++;
    if (row_ptr >= active_length()) begin
      row_ptr = 0;
      if (!cfg_loop) running = 1'b0;
    end
    was_running = running;
    return pulses;
  endfunction

  function automatic void issue(input logic [2:0] f, input logic [9:0] r,
                                input logic [1:0] m, input logic [31:0] v);
    request_t req;
    outcome_t res;
    req = '{f, r, m, v};
    res.pulse = '0;
    case (f)
      FUNC_TICK: begin
        step_triggers();
        res.pulse = step_motors();
      end
      FUNC_LOAD: if (!running) begin
        targets[r][m] = v;
        loaded[r][m] = 1'b1;
      end
      FUNC_START: running = 1'b1;
      FUNC_STOP: running = 1'b0;
      FUNC_ZERO_ROW: if (!running) row_ptr = 0;
      FUNC_ZERO_POS: if (!running) for (int i = 0; i < 4; i++) position[i] = '0;
      default: ;
    endcase
    res.coils = coils;
    res.dir   = held_dir;
    res.trig  = {trig_on[1], trig_on[0]};
    res.ptr   = row_ptr[9:0];
    res.run   = running;
    res.pos   = position[m];
    pending_requests.push_back(req);
    predicted_results.push_back(res);
    if (counting) random_items++;
  endfunction

  function automatic logic [31:0] pick_target();
    return ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(40)) - 32'd20;
  endfunction

  // A tick reads its row and row 0; while running, rows never loaded are filled in first.
  function automatic void issue_tick();
    int r;
    bit gap, was_on;
    r = (!was_running && row_ptr >= active_length()) ? 0 : row_ptr;
    gap = 1'b0;
    for (int i = 0; i < 4; i++) gap |= running && (!loaded[r][i] || !loaded[0][i]);
    if (gap) begin
      was_on = running;
      if (was_on) issue(FUNC_STOP, 10'($urandom()), 2'($urandom()), $urandom());
      for (int i = 0; i < 4; i++) begin
        if (!loaded[0][i]) issue(FUNC_LOAD, 10'd0, 2'(i), pick_target());
        if (!loaded[r][i]) issue(FUNC_LOAD, 10'(r), 2'(i), pick_target());
      end
      if (was_on) issue(FUNC_START, 10'($urandom()), 2'($urandom()), $urandom());
    end
    issue(FUNC_TICK, 10'($urandom()), 2'($urandom()), $urandom());
  endfunction

  task automatic drain();
    while (pending_requests.size() != 0 || predicted_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ApbAddrW'(idx) << 2; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TABLE_LENGTH: cfg_len = v[10:0];
      REG_LOOP_MODE:    cfg_loop = v[0];
      REG_MOVE_MODE:    cfg_move = v[0];
      REG_TRIG0_ROW:    cfg_trow[0] = v[10:0];
      REG_TRIG0_WIDTH:  cfg_twid[0] = v[15:0];
      REG_TRIG1_ROW:    cfg_trow[1] = v[10:0];
      REG_TRIG1_WIDTH:  cfg_twid[1] = v[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [10:0] len, input bit lp, input bit mv,
                           input logic [10:0] r0, input logic [15:0] w0,
                           input logic [10:0] r1, input logic [15:0] w1);
    drain();
    write_reg(REG_TABLE_LENGTH, 32'(len));
    write_reg(REG_LOOP_MODE, 32'(lp));
    write_reg(REG_MOVE_MODE, 32'(mv));
    write_reg(REG_TRIG0_ROW, 32'(r0));
    write_reg(REG_TRIG0_WIDTH, 32'(w0));
    write_reg(REG_TRIG1_ROW, 32'(r1));
    write_reg(REG_TRIG1_WIDTH, 32'(w1));
  endtask

  function automatic void issue_noise();
    logic [2:0] f;
    f = 3'($urandom());
    if (f == FUNC_TICK) issue_tick();
    else issue(f, 10'($urandom()), 2'($urandom()), $urandom());
  endfunction

  // Driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_requests.size() != 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
        request_t req;
        req = pending_requests.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func  <= req.func;
        in_ch.row   <= req.row;
        in_ch.motor <= req.motor;
        in_ch.value <= req.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          failed = 1'b1;
        end else begin
          outcome_t e;
          e = predicted_results.pop_front();
          compare("step_pattern", 32'(e.coils), 32'(out_ch.step_pattern));
          compare("clock_pulse", 32'(e.pulse), 32'(out_ch.clock_pulse));
          compare("direction_level", 32'(e.dir), 32'(out_ch.direction_level));
          compare("trigger_level", 32'(e.trig), 32'(out_ch.trigger_level));
          compare("row_pointer", 32'(e.ptr), 32'(out_ch.row_pointer));
          compare("running", 32'(e.run), 32'(out_ch.running));
          compare("selected_position", e.pos, out_ch.selected_position);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    #20ms;
    $display("motor_trajectory_outscan_core verification failed");
    $finish;
  end

  initial begin
    int phase_no;
    int ticks;
    int rows;
    logic [10:0] len;
    in_ch.valid = 1'b0; in_ch.func = '0; in_ch.row = '0; in_ch.motor = '0; in_ch.value = '0;
    out_ch.ready = 1'b0;
    cfg_len = 11'd1; cfg_loop = 1'b0; cfg_move = 1'b0;
    cfg_trow = '{11'h7ff, 11'h7ff}; cfg_twid = '{16'd1, 16'd1};
    for (int r = 0; r < 1024; r++) for (int i = 0; i < 4; i++) loaded[r][i] = 1'b0;
    for (int i = 0; i < 4; i++) begin position[i] = '0; origin[i] = '0; end
    phase = '{3'd0, 3'd0}; held_dir = '0; coils = '0; row_ptr = 0;
    running = 1'b0; was_running = 1'b0;
    trig_on = '{1'b0, 1'b0}; trig_count = '{16'd0, 16'd0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: defaults, unknown codes, extremes and ignored commands.
    issue_tick();
    issue(3'd6, 10'h3ff, 2'd3, 32'hffffffff);
    issue(3'd7, 10'h000, 2'd0, 32'h0);
    issue(FUNC_ZERO_POS, 10'd0, 2'd1, 32'd0);
    issue(FUNC_ZERO_ROW, 10'd0, 2'd2, 32'd0);
    issue(FUNC_LOAD, 10'd0, 2'd0, 32'h7fffffff);
    issue(FUNC_LOAD, 10'd0, 2'd1, 32'h80000000);
    issue(FUNC_LOAD, 10'd0, 2'd2, 32'h0);
    issue(FUNC_LOAD, 10'd0, 2'd3, 32'hffffffff);
    issue(FUNC_LOAD, 10'h3ff, 2'd3, 32'h80000000);
    issue(FUNC_START, 10'd0, 2'd0, 32'd0);
    issue(FUNC_START, 10'd0, 2'd0, 32'd0);
    issue_tick();
    configure(11'd3, 1'b1, 1'b0, 11'd1, 16'd0, 11'd0, 16'd2);
    issue(FUNC_LOAD, 10'd1, 2'd0, 32'h7fffffff + 32'd2);
    issue(FUNC_LOAD, 10'd1, 2'd1, 32'h80000000 - 32'd2);
    issue(FUNC_LOAD, 10'd2, 2'd2, 32'd3);
    issue(FUNC_START, 10'd0, 2'd0, 32'd0);
    repeat (4) issue_tick();
    issue(FUNC_LOAD, 10'd1, 2'd3, 32'd9);
    issue(FUNC_ZERO_ROW, 10'd0, 2'd3, 32'd0);
    issue(FUNC_ZERO_POS, 10'd0, 2'd3, 32'd0);
    issue(FUNC_STOP, 10'd0, 2'd1, 32'd0);
    issue_tick();
    configure(11'd0, 1'b0, 1'b1, 11'd0, 16'hffff, 11'h7ff, 16'd1);
    issue(FUNC_START, 10'd0, 2'd0, 32'd0);
    issue_tick();
    issue_tick();

    // Random phases of well-formed runs with some noise.
    counting = 1'b1;
    phase_no = 0;
    while (random_items < 400) begin
      case ($urandom_range(9))
        0: len = 11'd0;
        1: len = 11'd1024;
        2: len = 11'h7ff;
        3: len = 11'($urandom());
        default: len = 11'($urandom_range(1, 8));
      endcase
      configure(len, 1'($urandom()), ($urandom_range(3) == 0),
                ($urandom_range(4) == 0) ? 11'($urandom()) : 11'($urandom_range(0, 9)) - 11'd1,
                ($urandom_range(5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 5)),
                ($urandom_range(4) == 0) ? 11'($urandom()) : 11'($urandom_range(0, 9)) - 11'd1,
                ($urandom_range(5) == 0) ? 16'hffff : 16'($urandom_range(0, 5)));
      idle_pct = (phase_no == 3 || phase_no == 4) ? 0 : 30;
      rows = (active_length() < 8) ? active_length() : 8;
      if (rows == 0) rows = 1;
      for (int r = 0; r < rows; r++)
        for (int i = 0; i < 4; i++) issue(FUNC_LOAD, 10'(r), 2'(i), pick_target());
      if ($urandom_range(2) == 0) issue(FUNC_ZERO_ROW, 10'd0, 2'($urandom()), 32'd0);
      if ($urandom_range(3) == 0) issue(FUNC_ZERO_POS, 10'd0, 2'($urandom()), 32'd0);
      issue(FUNC_START, 10'($urandom()), 2'($urandom()), $urandom());
      ticks = $urandom_range(5, 30);
      for (int k = 0; k < ticks; k++) begin
        if ($urandom_range(9) == 0) issue_noise();
        else issue_tick();
      end
      if ($urandom_range(1) == 0) issue(FUNC_STOP, 10'd0, 2'($urandom()), 32'd0);
      if (phase_no == 2) begin
        hold_sender = 1'b1;
        while (predicted_results.size() > pending_requests.size()) @(posedge clk_i);
        repeat (3) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      phase_no++;
    end

    while (pending_requests.size() != 0 || predicted_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (!failed) begin
      $display("motor_trajectory_outscan_core verification clean");
    end else begin
      $display("motor_trajectory_outscan_core verification failed");
    end
    $finish;
  end

endmodule

// File: motor_trajectory_outscan_core.f
rtl/core/mtos_pkg.sv
rtl/core/mtos_if.sv
rtl/core/mtos_regs.sv
rtl/core/motor_trajectory_outscan_core.sv
sim/motor_trajectory_outscan_core_test.sv
